// ----- rtl/coordinate_hash_star_generator_core_macros.svh -----
// ----------------------------------------------------------------------------
// Star generator assertion macros
// Shared assertion forms for the coordinate hash star generator.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_HASH_STAR_GENERATOR_CORE_MACROS_SVH
`define COORDINATE_HASH_STAR_GENERATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHSG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/chsg_pkg.sv -----
// ----------------------------------------------------------------------------
// Star generator package
// Payload types, hash constants and stage control type for the star generator.
// ----------------------------------------------------------------------------
`default_nettype none

package chsg_pkg;

   localparam logic [31:0] SEED_STEP  = 32'he120fc15;
   localparam logic [31:0] SEED_STEP2 = SEED_STEP + SEED_STEP;
   localparam logic [31:0] SEED_STEP3 = SEED_STEP2 + SEED_STEP;
   localparam logic [31:0] MUL_A      = 32'h4a39b70d;
   localparam logic [31:0] MUL_B      = 32'h12fad5c9;

   // Quotient by 25 of a 31-bit value is (v * DIV25_RECIP) >> DIV25_SHIFT.
   localparam logic [31:0] DIV25_RECIP = 32'd2748779070;
   localparam int          DIV25_SHIFT = 36;
   localparam int          Q25_WIDTH   = 27;
   localparam logic [4:0]  STAR_HIT_HALF = 5'd1;

   // Quotient by 5 of a 7-bit value is (v * DIV5_RECIP) >> DIV5_SHIFT.
   localparam logic [14:0] DIV5_RECIP = 15'd205;
   localparam int          DIV5_SHIFT = 10;

   localparam logic [5:0]  STAR_SIZE_MIN = 6'd3;

   typedef struct packed {
      logic [15:0] sector_x;
      logic [15:0] sector_y;
   } req_type;

   typedef struct packed {
      logic       star_present;
      logic [5:0] star_size;
      logic [2:0] color_index;
   } rsp_type;

   typedef struct packed {
      logic mul_a;
      logic mul_b;
   } chsg_adv_type;

endpackage

`default_nettype wire

// ----- rtl/chsg_draw.sv -----
// ----------------------------------------------------------------------------
// Star generator hash draw
// Two registered multiply stages with high/low XOR folding for one draw.
// ----------------------------------------------------------------------------
`default_nettype none

module chsg_draw (
   input  wire logic                  clock,
   input  wire chsg_pkg::chsg_adv_type adv,
   input  wire logic [31:0]           seed,
   output logic [31:0]                draw
);
   import chsg_pkg::*;

   logic [63:0] prod_a_ff;
   logic [63:0] prod_a_in;
   logic [63:0] prod_b_ff;
   logic [63:0] prod_b_in;
   logic [31:0] fold_a;

   assign prod_a_in = {32'd0, seed} * {32'd0, MUL_A};
   assign fold_a    = prod_a_ff[63:32] ^ prod_a_ff[31:0];
   assign prod_b_in = {32'd0, fold_a} * {32'd0, MUL_B};
   assign draw      = prod_b_ff[63:32] ^ prod_b_ff[31:0];

   always_ff @(posedge clock) begin
      if (adv.mul_a) begin
         prod_a_ff <= prod_a_in;
      end
      if (adv.mul_b) begin
         prod_b_ff <= prod_b_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/coordinate_hash_star_generator_core.sv -----
// ----------------------------------------------------------------------------
// Coordinate hash star generator core
// Each sector passes seed, product, division-term and result stages in order.
// Throughput is one sector per cycle while the result is not stalled.
// A stalled result holds while empty stages behind it keep filling.
// Reset clears the stage valid bits and stalls the input; payloads are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coordinate_hash_star_generator_core_macros.svh"

module coordinate_hash_star_generator_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire chsg_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output chsg_pkg::rsp_type      rsp_data
);
   import chsg_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   logic [31:0] seed;
   logic [31:0] seed1_ff, seed2_ff, seed3_ff;
   logic [31:0] seed1_in, seed2_in, seed3_in;

   chsg_adv_type adv;
   logic [31:0]  draw1, draw2, draw3;

   logic [63:0]          recip_prod;
   logic [30:0]          half_ff;
   logic [30:0]          half_in;
   logic [Q25_WIDTH-1:0] q25_ff;
   logic [Q25_WIDTH-1:0] q25_in;
   logic                 lsb_ff;
   logic [4:0]           size5_ff;
   logic [6:0]           nib_sum_ff;
   logic [6:0]           nib_sum_in;

   logic [30:0] q25_times;
   logic [30:0] rem25;
   logic [14:0] div5_prod;
   logic [6:0]  q5;
   logic [6:0]  rem5;
   logic        present;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   assign rdy5      = !v5_ff || !rsp_stall;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = reset || !rdy1;

   assign seed     = {req_data.sector_x, req_data.sector_y};
   assign seed1_in = seed + SEED_STEP;
   assign seed2_in = seed + SEED_STEP2;
   assign seed3_in = seed + SEED_STEP3;

   assign adv.mul_a = rdy2 && v1_ff;
   assign adv.mul_b = rdy3 && v2_ff;

   chsg_draw u_draw1 (.clock(clock), .adv(adv), .seed(seed1_ff), .draw(draw1));
   chsg_draw u_draw2 (.clock(clock), .adv(adv), .seed(seed2_ff), .draw(draw2));
   chsg_draw u_draw3 (.clock(clock), .adv(adv), .seed(seed3_ff), .draw(draw3));

   always_comb begin
      half_in    = draw1[31:1];
      recip_prod = {33'd0, half_in} * {32'd0, DIV25_RECIP};
      q25_in     = recip_prod[DIV25_SHIFT +: Q25_WIDTH];
      nib_sum_in = 7'd0;
      for (int i = 0; i < 8; i++) begin
         nib_sum_in = nib_sum_in + {3'd0, draw3[4*i +: 4]};
      end
   end

   always_comb begin
      q25_times = (31'(q25_ff) << 4) + (31'(q25_ff) << 3) + 31'(q25_ff);
      rem25     = half_ff - q25_times;
      present   = !lsb_ff && (rem25[4:0] == STAR_HIT_HALF);
      div5_prod = {8'd0, nib_sum_ff} * DIV5_RECIP;
      q5        = {2'd0, div5_prod[DIV5_SHIFT +: 5]};
      rem5      = nib_sum_ff - ((q5 << 2) + q5);
      rsp_in.star_present = present;
      rsp_in.star_size    = present ? ({1'b0, size5_ff} + STAR_SIZE_MIN) : 6'd0;
      rsp_in.color_index  = present ? rem5[2:0] : 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         seed1_ff <= seed1_in;
         seed2_ff <= seed2_in;
         seed3_ff <= seed3_in;
      end
      if (rdy4 && v3_ff) begin
         half_ff    <= half_in;
         q25_ff     <= q25_in;
         lsb_ff     <= draw1[0];
         size5_ff   <= draw2[4:0];
         nib_sum_ff <= nib_sum_in;
      end
      if (rdy5 && v4_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v5_ff;
   assign rsp_data  = rsp_ff;

   `CHSG_ASSERT_NOW(a_absent_zero, clock, reset, rsp_valid && !rsp_data.star_present,
      (rsp_data.star_size == 6'd0) && (rsp_data.color_index == 3'd0),
      "Result without a star carries a nonzero size or color.")
   `CHSG_ASSERT_NOW(a_present_range, clock, reset, rsp_valid && rsp_data.star_present,
      (rsp_data.star_size >= 6'd3) && (rsp_data.star_size <= 6'd34) &&
      (rsp_data.color_index <= 3'd4),
      "Star result has size or color out of range.")
   `CHSG_ASSERT_NOW(a_stall_full, clock, reset, req_stall,
      v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && rsp_stall,
      "Input stalled while the pipeline has an empty stage.")
   `CHSG_ASSERT_NEXT(a_fill_on_stall, clock, reset, rsp_valid && rsp_stall && v4_ff,
      rsp_valid && v4_ff,
      "Pipeline lost an item while the result was stalled.")

endmodule

`default_nettype wire

// ----- sim/star_result_checker.sv -----
// ----------------------------------------------------------------------------
// Star result checker
// Predicts the star found in each sector that is transferred into the
// generator and compares every result transfer, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package star_hash_model_pkg;

   localparam logic [31:0] HASH_STEP   = 32'he120fc15;
   localparam logic [31:0] HASH_MUL_A  = 32'h4a39b70d;
   localparam logic [31:0] HASH_MUL_B  = 32'h12fad5c9;
   localparam logic [31:0] STAR_CHANCE = 32'd50;
   localparam logic [31:0] STAR_HIT    = 32'd2;
   localparam logic [31:0] SIZE_SPAN   = 32'd32;
   localparam logic [31:0] SIZE_BASE   = 32'd3;
   localparam logic [31:0] COLOR_COUNT = 32'd5;

   function automatic logic [31:0] fold_product(input logic [31:0] a, input logic [31:0] k);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, k};
      return p[63:32] ^ p[31:0];
   endfunction

   function automatic logic [31:0] hash_draw(input logic [31:0] seed);
      return fold_product(fold_product(seed, HASH_MUL_A), HASH_MUL_B);
   endfunction

   function automatic chsg_pkg::rsp_type predict_star(input chsg_pkg::req_type sector);
      logic [31:0]       seed;
      logic [31:0]       size_val;
      logic [31:0]       color_val;
      chsg_pkg::rsp_type star;
      seed = {sector.sector_x, sector.sector_y} + HASH_STEP;
      star = '0;
      if ((hash_draw(seed) % STAR_CHANCE) == STAR_HIT) begin
         seed = seed + HASH_STEP;
         size_val = (hash_draw(seed) % SIZE_SPAN) + SIZE_BASE;
         seed = seed + HASH_STEP;
         color_val = hash_draw(seed) % COLOR_COUNT;
         star.star_present = 1'b1;
         star.star_size = size_val[5:0];
         star.color_index = color_val[2:0];
      end
      return star;
   endfunction

endpackage

module star_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  chsg_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  chsg_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);

   chsg_pkg::rsp_type expected_stars[$];
   int                errors = 0;

   always @(posedge clock) begin
      chsg_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stars.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, actual %h",
                        $time, rsp_data);
               errors = errors + 1;
            end else begin
               want = expected_stars.pop_front();
               if (rsp_data.star_present !== want.star_present) begin
                  $display("%0t: star_present mismatch, expected %0d, actual %0d",
                           $time, want.star_present, rsp_data.star_present);
                  errors = errors + 1;
               end
               if (rsp_data.star_size !== want.star_size) begin
                  $display("%0t: star_size mismatch, expected %0d, actual %0d",
                           $time, want.star_size, rsp_data.star_size);
                  errors = errors + 1;
               end
               if (rsp_data.color_index !== want.color_index) begin
                  $display("%0t: color_index mismatch, expected %0d, actual %0d",
                           $time, want.color_index, rsp_data.color_index);
                  errors = errors + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_stars.push_back(star_hash_model_pkg::predict_star(req_data));
         end
      end
      fail_count <= errors;
      pending <= expected_stars.size();
   end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Star generator testbench
// Feeds directed and random sector coordinates in bursts while the result
// side stalls on its own pattern, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_SECTORS = 1500;
   localparam int CYCLE_LIMIT    = 200000;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   chsg_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   chsg_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending;
   int                cycle_count = 0;
   int                burst_left = 0;
   chsg_pkg::req_type directed_sectors[$];

   always #6 clock = ~clock;

   coordinate_hash_star_generator_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   star_result_checker star_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending(pending)
   );

   function automatic chsg_pkg::req_type find_star_sector(input logic [15:0] x,
                                                          input logic [15:0] y);
      chsg_pkg::req_type probe;
      chsg_pkg::rsp_type hit;
      probe = {x, y};
      hit = star_hash_model_pkg::predict_star(probe);
      while (!hit.star_present) begin
         probe.sector_y = probe.sector_y + 16'd1;
         hit = star_hash_model_pkg::predict_star(probe);
      end
      return probe;
   endfunction

   // Each burst may be preceded by an idle gap; the item is held until its transfer.
   task automatic send_sector(input chsg_pkg::req_type sector);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left = burst_left - 1;
      req_data <= sector;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("coordinate_hash_star_generator_core test failed");
         $finish;
      end
   end

   initial begin
      int round;
      int mode;
      int span;
      round = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         round = round + 1;
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 50);
         if (round == 3 || (mode == 3 && $urandom_range(0, 7) == 0)) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(40, 90)) @(posedge clock);
         end else begin
            repeat (span) begin
               rsp_stall <= ($urandom_range(0, 3) < mode);
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      directed_sectors.push_back({16'h0000, 16'h0000});
      directed_sectors.push_back({16'hFFFF, 16'hFFFF});
      directed_sectors.push_back({16'h0000, 16'hFFFF});
      directed_sectors.push_back({16'hFFFF, 16'h0000});
      directed_sectors.push_back({16'h5555, 16'hAAAA});
      directed_sectors.push_back({16'hAAAA, 16'h5555});
      directed_sectors.push_back({16'h8000, 16'h7FFF});
      directed_sectors.push_back({16'h7FFF, 16'h8000});
      directed_sectors.push_back({16'h0001, 16'h0001});
      directed_sectors.push_back({16'hFFFE, 16'hFFFE});
      directed_sectors.push_back(find_star_sector(16'h0000, 16'h0000));
      directed_sectors.push_back(find_star_sector(16'hFFFF, 16'h0000));
      directed_sectors.push_back(find_star_sector(16'h1234, 16'h8000));
      directed_sectors.push_back(find_star_sector(16'hAAAA, 16'h5555));
      directed_sectors.push_back(find_star_sector(16'hFFFF, 16'hF000));
      for (int y = 0; y < 5; y++) begin
         directed_sectors.push_back({16'h0100, 16'(y)});
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_sectors[i]) begin
         send_sector(directed_sectors[i]);
      end
      repeat (RANDOM_SECTORS) begin
         send_sector({16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))});
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("coordinate_hash_star_generator_core test passed");
      end else begin
         $display("coordinate_hash_star_generator_core test failed");
      end
      $finish;
   end

endmodule
